FILE: hw/rtl/sgdlr_pkg.sv
// shared types, widths, codes and saturation helper for the sgd trainer
package sgdlr_pkg;

    localparam int DATA_W = 32;
    localparam int ACC_W  = 64;
    localparam int STEP_W = 16;
    localparam int Q_FRAC = 16;
    // multiplier operand width: covers the 33-bit scaled gradient
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;
    // gradient = floor(err * step * 2 / 2^16) = floor(err * step / 2^15)
    localparam int G_LSB  = Q_FRAC - 1;
    // working width for every add/subtract that saturates to DATA_W
    localparam int SAT_W  = 50;

    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(655);

    localparam logic KIND_PRED = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef enum logic [1:0] {
        CMD_TRAIN   = 2'd0,
        CMD_PREDICT = 2'd1,
        CMD_READ    = 2'd2,
        CMD_WRITE   = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAC_MUL,
        S_MAC_ACC,
        S_PRED,
        S_ERR,
        S_GRAD_MUL,
        S_GRAD,
        S_UPD_RD,
        S_UPD_MUL,
        S_UPD_WR,
        S_BIAS,
        S_RD_OUT,
        S_EMIT
    } state_t;

    typedef logic signed [DATA_W-1:0] data_t;

    function automatic data_t sat_data(input logic signed [SAT_W-1:0] v);
        data_t r;
        if (v[SAT_W-1:DATA_W-1] == {(SAT_W-DATA_W+1){v[SAT_W-1]}})
        begin
            r = v[DATA_W-1:0];
        end
        else if (v[SAT_W-1])
        begin
            r = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(DATA_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/sgdlr_if.sv
// sample and result channel interfaces
interface sgdlr_in_if
    import sgdlr_pkg::*;
#(
    parameter int IDX_W = 5
);
    logic              valid;
    logic              ready;
    cmd_t              command;
    data_t             value;
    data_t             target;
    logic [IDX_W-1:0]  weight_index;
    logic              last_feature;

    modport source (output valid, command, value, target, weight_index, last_feature,
                    input ready);
    modport sink   (input valid, command, value, target, weight_index, last_feature,
                    output ready);
endinterface

interface sgdlr_out_if
    import sgdlr_pkg::*;
;
    logic   valid;
    logic   ready;
    data_t  result_value;
    logic   result_kind;
    data_t  error_value;

    modport source (output valid, result_value, result_kind, error_value, input ready);
    modport sink   (input valid, result_value, result_kind, error_value, output ready);
endinterface

FILE: hw/rtl/sgdlr_ram.sv
// generic single write port ram with registered read
module sgdlr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

FILE: hw/rtl/sgdlr_mul.sv
// shared signed multiplier with registered product
module sgdlr_mul
    import sgdlr_pkg::*;
(
    input  logic                     clk,
    input  logic signed [MUL_W-1:0]  a,
    input  logic signed [MUL_W-1:0]  b,
    output logic signed [PROD_W-1:0] p
);
    logic signed [PROD_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;
endmodule

FILE: hw/rtl/sgd_linear_regression_trainer.sv
// top level of the fixed-point linear regression sgd trainer
//
// samples arrive one feature word at a time on the sample channel; every
// word is consumed by a small sequencer around one shared 33x33 multiplier
// and two rams with a write and a read port each (weights, stored features),
// so the block is ready only while its sequencer is idle. a weight write is
// done on acceptance; a readback emits the entry; a stored feature runs a
// weight fetch, multiply and accumulate, and the last feature of a sample
// then forms the prediction; for a train sample it also forms the error and
// gradient and runs an update pass that fetches, multiplies and writes back
// one weight at a time through the same multiplier and weight ram port.
// words that exceed MAX_FEATURES are dropped but their last mark still
// ends the sample, without a multiply and accumulate. results pass through
// an output register, so the next word is accepted while a result still
// waits; the sequencer stalls only if a new result is ready while the
// previous one has not been taken. the weight ram is cleared after reset
// through one valid bit per entry, so no clearing pass is needed. all data
// values are signed q16.16 and saturate.
module sgd_linear_regression_trainer
    import sgdlr_pkg::*;
#(
    parameter int MAX_FEATURES = 16,
    localparam int IDX_W  = $clog2(MAX_FEATURES + 1),
    localparam int ADDR_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [STEP_W-1:0] cfg_wr_data,
    sgdlr_in_if.sink          samples,
    sgdlr_out_if.source       results
);
    // index MAX_FEATURES addresses the bias
    localparam logic [IDX_W-1:0] BIAS_IDX = IDX_W'(MAX_FEATURES);

    state_t state_reg, state_next;

    logic [STEP_W-1:0]       step_reg;
    logic [IDX_W-1:0]        pos_reg;
    logic [IDX_W-1:0]        j_reg;
    logic [IDX_W-1:0]        j_inc;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    data_t                   bias_reg;
    logic [MAX_FEATURES-1:0] wvalid_reg;
    logic                    wvld_rd_reg;

    // latched sample word
    cmd_t             cmd_reg;
    data_t            val_reg;
    data_t            tgt_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             last_reg;

    // working values
    logic signed [MUL_W-1:0] g_reg;
    data_t                   w_hold_reg;
    data_t                   res_val_reg;
    data_t                   res_err_reg;
    logic                    res_kind_reg;

    // output register
    logic  out_valid_reg;
    data_t out_val_reg;
    data_t out_err_reg;
    logic  out_kind_reg;

    // ram and multiplier hookup
    logic              w_we, w_re, f_we, f_re;
    logic [ADDR_W-1:0] w_waddr, w_raddr;
    data_t             w_wdata;
    data_t             w_rdata, f_rdata;
    data_t             rd_word;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;

    logic accept, is_feat, pos_room, out_free;
    logic signed [ACC_W:0]   acc_sum;
    logic signed [SAT_W-1:0] upd_d;
    data_t pred_sat, err_sat, bias_sat, w_new, rd_back;

    assign accept   = samples.valid && samples.ready;
    assign is_feat  = (samples.command == CMD_TRAIN) || (samples.command == CMD_PREDICT);
    assign pos_room = pos_reg < BIAS_IDX;
    assign out_free = !out_valid_reg || results.ready;
    assign j_inc    = j_reg + 1'b1;

    // an entry never written since reset reads as zero
    assign rd_word = wvld_rd_reg ? w_rdata : '0;

    sgdlr_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_FEATURES)
    ) u_weight_ram (
        .clk   (clk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (w_wdata),
        .re    (w_re),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    sgdlr_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_FEATURES)
    ) u_feature_ram (
        .clk   (clk),
        .we    (f_we),
        .waddr (pos_reg[ADDR_W-1:0]),
        .wdata (samples.value),
        .re    (f_re),
        .raddr (j_reg[ADDR_W-1:0]),
        .rdata (f_rdata)
    );

    sgdlr_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    // datapath arithmetic
    always_comb
    begin
        acc_sum  = {acc_reg[ACC_W-1], acc_reg} + {mul_p[ACC_W-1], mul_p[ACC_W-1:0]};
        if (acc_sum[ACC_W] != acc_sum[ACC_W-1])
        begin
            acc_next = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                      : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            acc_next = acc_sum[ACC_W-1:0];
        end
        pred_sat = sat_data(SAT_W'($signed(acc_reg[ACC_W-1:Q_FRAC])) + SAT_W'(bias_reg));
        err_sat  = sat_data(SAT_W'(res_val_reg) - SAT_W'(tgt_reg));
        bias_sat = sat_data(SAT_W'(bias_reg) - SAT_W'(g_reg));
        upd_d    = mul_p[Q_FRAC+SAT_W-1:Q_FRAC];
        w_new    = sat_data(SAT_W'(w_hold_reg) - upd_d);
        if (idx_reg < BIAS_IDX)
        begin
            rd_back = rd_word;
        end
        else if (idx_reg == BIAS_IDX)
        begin
            rd_back = bias_reg;
        end
        else
        begin
            rd_back = '0;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (samples.command)
                        CMD_READ:  state_next = S_RD_OUT;
                        CMD_WRITE: state_next = S_IDLE;
                        default:
                        begin
                            if (pos_room)
                            begin
                                state_next = S_MAC_MUL;
                            end
                            else if (samples.last_feature)
                            begin
                                state_next = S_PRED;
                            end
                        end
                    endcase
                end
            end
            S_MAC_MUL:  state_next = S_MAC_ACC;
            S_MAC_ACC:  state_next = last_reg ? S_PRED : S_IDLE;
            S_PRED:     state_next = (cmd_reg == CMD_TRAIN) ? S_ERR : S_EMIT;
            S_ERR:      state_next = S_GRAD_MUL;
            S_GRAD_MUL: state_next = S_GRAD;
            S_GRAD:     state_next = (pos_reg == '0) ? S_BIAS : S_UPD_RD;
            S_UPD_RD:   state_next = S_UPD_MUL;
            S_UPD_MUL:  state_next = S_UPD_WR;
            S_UPD_WR:   state_next = (j_inc == pos_reg) ? S_BIAS : S_UPD_RD;
            S_BIAS:     state_next = S_EMIT;
            S_RD_OUT:   state_next = S_EMIT;
            S_EMIT:     state_next = out_free ? S_IDLE : S_EMIT;
            default:    state_next = S_IDLE;
        endcase
    end

    // control outputs: ram ports and multiplier operands
    always_comb
    begin
        w_we    = 1'b0;
        w_waddr = samples.weight_index[ADDR_W-1:0];
        w_wdata = samples.value;
        w_re    = 1'b0;
        w_raddr = pos_reg[ADDR_W-1:0];
        f_we    = 1'b0;
        f_re    = 1'b0;
        mul_a   = '0;
        mul_b   = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && is_feat && pos_room)
                begin
                    f_we = 1'b1;
                    w_re = 1'b1;
                end
                if (accept && (samples.command == CMD_READ)
                    && (samples.weight_index < BIAS_IDX))
                begin
                    w_re    = 1'b1;
                    w_raddr = samples.weight_index[ADDR_W-1:0];
                end
                if (accept && (samples.command == CMD_WRITE)
                    && (samples.weight_index < BIAS_IDX))
                begin
                    w_we = 1'b1;
                end
            end
            S_MAC_MUL:
            begin
                mul_a = MUL_W'(rd_word);
                mul_b = MUL_W'(val_reg);
            end
            S_GRAD_MUL:
            begin
                mul_a = MUL_W'(res_err_reg);
                mul_b = MUL_W'({1'b0, step_reg});
            end
            S_UPD_RD:
            begin
                w_re    = 1'b1;
                f_re    = 1'b1;
                w_raddr = j_reg[ADDR_W-1:0];
            end
            S_UPD_MUL:
            begin
                mul_a = g_reg;
                mul_b = MUL_W'(f_rdata);
            end
            S_UPD_WR:
            begin
                w_we    = 1'b1;
                w_waddr = j_reg[ADDR_W-1:0];
                w_wdata = w_new;
            end
            default:
            begin
            end
        endcase
    end

    assign samples.ready        = (state_reg == S_IDLE);
    assign results.valid        = out_valid_reg;
    assign results.result_value = out_val_reg;
    assign results.result_kind  = out_kind_reg;
    assign results.error_value  = out_err_reg;

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= STEP_RESET;
            pos_reg       <= '0;
            j_reg         <= '0;
            acc_reg       <= '0;
            bias_reg      <= '0;
            wvalid_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                step_reg <= cfg_wr_data;
            end
            if (w_we)
            begin
                wvalid_reg[w_waddr] <= 1'b1;
            end
            if (accept && (samples.command == CMD_WRITE)
                && (samples.weight_index == BIAS_IDX))
            begin
                bias_reg <= samples.value;
            end
            unique case (state_reg)
                S_MAC_ACC:
                begin
                    acc_reg <= acc_next;
                    pos_reg <= pos_reg + 1'b1;
                end
                S_PRED:
                begin
                    acc_reg <= '0;
                    if (cmd_reg != CMD_TRAIN)
                    begin
                        pos_reg <= '0;
                    end
                end
                S_GRAD:   j_reg <= '0;
                S_UPD_WR: j_reg <= j_inc;
                S_BIAS:
                begin
                    bias_reg <= bias_sat;
                    pos_reg  <= '0;
                end
                default:
                begin
                end
            endcase
            if (state_reg == S_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (w_re)
        begin
            wvld_rd_reg <= wvalid_reg[w_raddr];
        end
        if (accept)
        begin
            cmd_reg  <= samples.command;
            val_reg  <= samples.value;
            tgt_reg  <= samples.target;
            idx_reg  <= samples.weight_index;
            last_reg <= samples.last_feature;
        end
        unique case (state_reg)
            S_PRED:
            begin
                res_val_reg  <= pred_sat;
                res_err_reg  <= '0;
                res_kind_reg <= KIND_PRED;
            end
            S_ERR:     res_err_reg <= err_sat;
            S_GRAD:    g_reg <= mul_p[G_LSB+MUL_W-1:G_LSB];
            S_UPD_MUL: w_hold_reg <= rd_word;
            S_RD_OUT:
            begin
                res_val_reg  <= rd_back;
                res_err_reg  <= '0;
                res_kind_reg <= KIND_READ;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_val_reg  <= res_val_reg;
                    out_err_reg  <= res_err_reg;
                    out_kind_reg <= res_kind_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // feature count never runs past the weight vector
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= BIAS_IDX)
        else $error("feature position beyond MAX_FEATURES");

    // update pass only touches weights of the current sample
    a_upd_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD_RD) |-> (j_reg < pos_reg))
        else $error("update index outside stored features");

    // a new result waits while the previous one is still held
    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && results.valid && !results.ready)
        |=> (state_reg == S_EMIT))
        else $error("result register overwritten before it was taken");

    // an empty sample always starts from a cleared accumulator
    a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && pos_reg == '0) |-> (acc_reg == '0))
        else $error("accumulator not cleared at sample start");

endmodule
